>>> hdl/tsjs_pkg.sv
// Types and constants shared by the two-stage job sequencer and its checker.
package tsjs_pkg;

   typedef logic [2:0]  status_type;
   typedef logic [1:0]  target_type;
   typedef logic [31:0] seq_type;
   typedef logic [3:0]  phase_code_type;

   localparam status_type ST_IDLE  = 3'd1;
   localparam status_type ST_PROC  = 3'd2;
   localparam status_type ST_DONE  = 3'd3;
   localparam status_type ST_FAULT = 3'd4;

   localparam target_type TGT_NONE = 2'd0;
   localparam target_type TGT_PRE  = 2'd1;
   localparam target_type TGT_DEP  = 2'd2;

   localparam phase_code_type PH_IDLE     = 4'd0;
   localparam phase_code_type PH_PRE_SENT = 4'd1;
   localparam phase_code_type PH_PRE_RUN  = 4'd2;
   localparam phase_code_type PH_PRE_DONE = 4'd3;
   localparam phase_code_type PH_DEP_SENT = 4'd4;
   localparam phase_code_type PH_DEP_RUN  = 4'd5;
   localparam phase_code_type PH_COMPLETE = 4'd7;
   localparam phase_code_type PH_ERROR    = 4'd8;

   typedef enum logic [7:0] {
      PS_IDLE     = 8'b0000_0001,
      PS_PRE_SENT = 8'b0000_0010,
      PS_PRE_RUN  = 8'b0000_0100,
      PS_PRE_DONE = 8'b0000_1000,
      PS_DEP_SENT = 8'b0001_0000,
      PS_DEP_RUN  = 8'b0010_0000,
      PS_COMPLETE = 8'b0100_0000,
      PS_ERROR    = 8'b1000_0000
   } phase_type;

   function automatic phase_code_type phase_code(input phase_type ps);
      phase_code_type code;
      unique case (ps)
         PS_IDLE:     code = PH_IDLE;
         PS_PRE_SENT: code = PH_PRE_SENT;
         PS_PRE_RUN:  code = PH_PRE_RUN;
         PS_PRE_DONE: code = PH_PRE_DONE;
         PS_DEP_SENT: code = PH_DEP_SENT;
         PS_DEP_RUN:  code = PH_DEP_RUN;
         PS_COMPLETE: code = PH_COMPLETE;
         PS_ERROR:    code = PH_ERROR;
         default:     code = PH_ERROR;
      endcase
      return code;
   endfunction

endpackage

>>> hdl/two_stage_job_sequencer.sv
// Two-stage job sequencer: input register, phase/sequence update, result register.
// The phase update is a single step off the input register, ahead of the result register.
// Throughput: one beat per cycle while no stalled result beat blocks the input register.
// A stalled result holds the result register; the input register still takes one more beat.
// Reset (synchronous, active high): phase to idle, sequence counter to zero,
// both pipeline valid flags cleared.
module two_stage_job_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_pending_valid,
   input  logic                     req_pre_registered,
   input  logic                     req_pre_healthy,
   input  tsjs_pkg::status_type     req_pre_status,
   input  logic                     req_dep_registered,
   input  logic                     req_dep_healthy,
   input  tsjs_pkg::status_type     req_dep_status,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_send_now,
   output tsjs_pkg::target_type     rsp_target_module,
   output tsjs_pkg::seq_type        rsp_command_seq,
   output tsjs_pkg::phase_code_type rsp_job_phase
);
   import tsjs_pkg::*;

   // input register
   logic       in_valid_ff;
   logic       pend_ff, preg_ff, phl_ff, dreg_ff, dhl_ff;
   status_type pst_ff, dst_ff;

   // job state
   phase_type  phase_ff, phase_in;
   seq_type    seq_ff, seq_in;

   // result register
   logic           out_valid_ff;
   logic           send_ff, send_in;
   target_type     target_ff, target_in;
   seq_type        cmd_seq_ff, cmd_seq_in;
   phase_code_type job_phase_ff;

   logic advance, req_take;
   logic pre_act, dep_act, fault;
   logic pre_done, dep_done, pre_idle, dep_idle;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign pre_act  = (phase_ff == PS_PRE_SENT) || (phase_ff == PS_PRE_RUN);
   assign dep_act  = (phase_ff == PS_DEP_SENT) || (phase_ff == PS_DEP_RUN);
   assign fault    = (pre_act && preg_ff && !phl_ff) || (dep_act && dreg_ff && !dhl_ff) ||
                     (pst_ff == ST_FAULT) || (dst_ff == ST_FAULT);
   assign pre_done = preg_ff && phl_ff && (pst_ff == ST_DONE);
   assign pre_idle = preg_ff && phl_ff && (pst_ff == ST_IDLE);
   assign dep_done = dreg_ff && dhl_ff && (dst_ff == ST_DONE);
   assign dep_idle = dreg_ff && dhl_ff && (dst_ff == ST_IDLE);

   always_comb begin
      phase_in   = phase_ff;
      seq_in     = seq_ff;
      send_in    = 1'b0;
      target_in  = TGT_NONE;
      cmd_seq_in = '0;
      if (!pend_ff) begin
         if (fault) begin
            phase_in = PS_ERROR;
         end else begin
            unique case (phase_ff)
               PS_IDLE: begin
                  priority if (pre_done && dep_done) begin
                     phase_in = PS_COMPLETE;
                  end else if (pre_done && dep_idle) begin
                     send_in   = 1'b1;
                     target_in = TGT_DEP;
                     phase_in  = PS_DEP_SENT;
                  end else if (pre_idle) begin
                     send_in   = 1'b1;
                     target_in = TGT_PRE;
                     phase_in  = PS_PRE_SENT;
                  end else begin
                     phase_in = phase_ff;
                  end
               end
               PS_PRE_SENT: begin
                  if (pst_ff == ST_PROC) begin
                     phase_in = PS_PRE_RUN;
                  end else if (pst_ff == ST_DONE) begin
                     phase_in = PS_PRE_DONE;
                  end
               end
               PS_PRE_RUN: begin
                  if (pst_ff == ST_DONE) begin
                     phase_in = PS_PRE_DONE;
                  end
               end
               PS_PRE_DONE: begin
                  if (dep_idle) begin
                     send_in   = 1'b1;
                     target_in = TGT_DEP;
                     phase_in  = PS_DEP_SENT;
                  end
               end
               PS_DEP_SENT: begin
                  if (dst_ff == ST_PROC) begin
                     phase_in = PS_DEP_RUN;
                  end else if (dst_ff == ST_DONE) begin
                     phase_in = PS_COMPLETE;
                  end
               end
               PS_DEP_RUN: begin
                  if (dst_ff == ST_DONE) begin
                     phase_in = PS_COMPLETE;
                  end
               end
               default: begin
               end
            endcase
            if (send_in) begin
               cmd_seq_in = seq_ff;
               seq_in     = seq_ff + 32'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PS_IDLE;
         seq_ff       <= '0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            seq_ff       <= seq_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         pend_ff <= req_pending_valid;
         preg_ff <= req_pre_registered;
         phl_ff  <= req_pre_healthy;
         pst_ff  <= req_pre_status;
         dreg_ff <= req_dep_registered;
         dhl_ff  <= req_dep_healthy;
         dst_ff  <= req_dep_status;
      end
      if (advance) begin
         send_ff      <= send_in;
         target_ff    <= target_in;
         cmd_seq_ff   <= cmd_seq_in;
         job_phase_ff <= phase_code(phase_in);
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_send_now      = send_ff;
   assign rsp_target_module = target_ff;
   assign rsp_command_seq   = cmd_seq_ff;
   assign rsp_job_phase     = job_phase_ff;

endmodule

>>> hdl/tsjs_checker.sv
// Port-level assertions for the two-stage job sequencer, with its bind.
module tsjs_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic                     rsp_send_now,
   input tsjs_pkg::target_type     rsp_target_module,
   input tsjs_pkg::seq_type        rsp_command_seq,
   input tsjs_pkg::phase_code_type rsp_job_phase
);
   import tsjs_pkg::*;

   // reset empties the result side
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // request side stalls only behind a stalled result beat
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled result beat");

   // a start beat names a module and lands in the matching sent phase
   a_send_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_now |->
         (rsp_target_module == TGT_PRE && rsp_job_phase == PH_PRE_SENT) ||
         (rsp_target_module == TGT_DEP && rsp_job_phase == PH_DEP_SENT))
      else $error("start beat with wrong target or phase");

   // no start: no target, sequence reads zero
   a_quiet_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_send_now |-> rsp_target_module == TGT_NONE && rsp_command_seq == '0)
      else $error("non-start beat carries target or sequence");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_send_now) &&
         $stable(rsp_target_module) && $stable(rsp_command_seq) && $stable(rsp_job_phase))
      else $error("stalled result beat changed");

endmodule

bind two_stage_job_sequencer tsjs_checker u_tsjs_checker (.*);
